/* rtl/gcd_pkg.sv */
// types shared by the gait cycle detector modules
package gcd_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned ForceW = 16;
  localparam int unsigned PosW = 16;
  localparam int unsigned CfgW = 32;

  // configuration register indexes
  localparam logic CFG_TOUCH_THRESHOLD = 1'b0;
  localparam logic CFG_MIN_STANCE_TIME = 1'b1;

  // record kinds
  localparam logic KIND_NEW = 1'b0;
  localparam logic KIND_EXTEND = 1'b1;

  // leg codes
  localparam logic LEG_LEFT = 1'b0;
  localparam logic LEG_RIGHT = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0] frame_time;
    logic signed [ForceW-1:0] force_left;
    logic signed [ForceW-1:0] force_right;
    logic signed [PosW-1:0] left_cop_x;
    logic signed [PosW-1:0] left_cop_y;
    logic signed [PosW-1:0] left_cop_z;
    logic signed [PosW-1:0] right_cop_x;
    logic signed [PosW-1:0] right_cop_y;
    logic signed [PosW-1:0] right_cop_z;
  } in_t;

  typedef struct packed {
    logic leg;
    logic kind;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] lift_time;
    logic [TimeW-1:0] stop_time;
    logic signed [PosW-1:0] start_x;
    logic signed [PosW-1:0] start_y;
    logic signed [PosW-1:0] start_z;
    logic signed [PosW-1:0] stop_x;
    logic signed [PosW-1:0] stop_y;
    logic signed [PosW-1:0] stop_z;
    logic final_of_frame;
  } out_t;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
  } cop_t;

  // what one leg reports for the frame in flight
  typedef struct packed {
    logic emit;
    logic kind;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] lift_time;
    cop_t start_pos;
  } leg_rec_t;

endpackage

/* rtl/gait_cycle_detector.sv */
// gait cycle detector top level: frame register, two leg machines, record queue
//
//   channel  ports                         moves
//   in       in_valid/in_ready/in_data     one sensor frame per transfer
//   out      out_valid/out_ready/out_data  one cycle record per transfer
//   cfg      cfg_wr_en/cfg_index/cfg_wdata register write, no handshake
//
// a frame is held in the frame register and its records enter the queue when it
// moves on; one frame per cycle is taken while the queue has room for two
// records, so a frame closing cycles on both legs yields two output records
// the record queue (QUEUE_DEPTH entries) decouples the output stall from input
// reset is synchronous, active low, and clears phases, flags, times and registers
module gait_cycle_detector #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gcd_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gcd_pkg::out_t                out_data,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [gcd_pkg::CfgW-1:0]     cfg_wdata
);

  logic signed [gcd_pkg::ForceW-1:0] touch_threshold_r;
  logic [gcd_pkg::TimeW-1:0] min_stance_time_r;

  logic frame_valid_r;
  gcd_pkg::in_t frame_r;
  logic advance;
  logic room;

  gcd_pkg::cop_t left_cop, right_cop;
  gcd_pkg::leg_rec_t left_rec, right_rec;
  gcd_pkg::out_t left_out, right_out;
  gcd_pkg::out_t push_a, push_b;
  logic [1:0] push_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_threshold_r <= '0;
      min_stance_time_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gcd_pkg::CFG_TOUCH_THRESHOLD: touch_threshold_r <= cfg_wdata[gcd_pkg::ForceW-1:0];
        gcd_pkg::CFG_MIN_STANCE_TIME: min_stance_time_r <= cfg_wdata[gcd_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  // the frame register moves on only when the queue can hold both records
  assign advance = frame_valid_r && room;
  assign in_ready = !frame_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
    end else if (in_ready) begin
      frame_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) frame_r <= in_data;
  end

  assign left_cop = '{x: frame_r.left_cop_x, y: frame_r.left_cop_y, z: frame_r.left_cop_z};
  assign right_cop = '{x: frame_r.right_cop_x, y: frame_r.right_cop_y,
                       z: frame_r.right_cop_z};

  gcd_leg u_leg_left (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (advance),
    .frame_time      (frame_r.frame_time),
    .leg_force       (frame_r.force_left),
    .cop             (left_cop),
    .touch_threshold (touch_threshold_r),
    .min_stance_time (min_stance_time_r),
    .rec             (left_rec)
  );

  gcd_leg u_leg_right (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (advance),
    .frame_time      (frame_r.frame_time),
    .leg_force       (frame_r.force_right),
    .cop             (right_cop),
    .touch_threshold (touch_threshold_r),
    .min_stance_time (min_stance_time_r),
    .rec             (right_rec)
  );

  always_comb begin
    left_out.leg = gcd_pkg::LEG_LEFT;
    left_out.kind = left_rec.kind;
    left_out.start_time = left_rec.start_time;
    left_out.lift_time = left_rec.lift_time;
    left_out.stop_time = frame_r.frame_time;
    left_out.start_x = left_rec.start_pos.x;
    left_out.start_y = left_rec.start_pos.y;
    left_out.start_z = left_rec.start_pos.z;
    left_out.stop_x = frame_r.left_cop_x;
    left_out.stop_y = frame_r.left_cop_y;
    left_out.stop_z = frame_r.left_cop_z;
    // left is last only when right closes nothing
    left_out.final_of_frame = !right_rec.emit;

    right_out.leg = gcd_pkg::LEG_RIGHT;
    right_out.kind = right_rec.kind;
    right_out.start_time = right_rec.start_time;
    right_out.lift_time = right_rec.lift_time;
    right_out.stop_time = frame_r.frame_time;
    right_out.start_x = right_rec.start_pos.x;
    right_out.start_y = right_rec.start_pos.y;
    right_out.start_z = right_rec.start_pos.z;
    right_out.stop_x = frame_r.right_cop_x;
    right_out.stop_y = frame_r.right_cop_y;
    right_out.stop_z = frame_r.right_cop_z;
    right_out.final_of_frame = 1'b1;

    push_a = left_rec.emit ? left_out : right_out;
    push_b = right_out;
    push_cnt = 2'd0;
    if (advance) push_cnt = {1'b0, left_rec.emit} + {1'b0, right_rec.emit};
  end

  gcd_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_a    (push_a),
    .push_b    (push_b),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a held frame with no room must stay put
  assert property (@(posedge clk) disable iff (!rst_n)
    (frame_valid_r && !room) |=> (frame_valid_r && $stable(frame_r)))
    else $error("frame dropped while queue full");

  // two records in one frame go left first, right last
  assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd2) |-> (push_a.leg == gcd_pkg::LEG_LEFT && !push_a.final_of_frame
                            && push_b.final_of_frame))
    else $error("record order within frame broken");

  assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> advance)
    else $error("records pushed without a frame transfer");

endmodule

/* rtl/gcd_leg.sv */
// per-leg phase machine: flight, touch, stance and swing tracking
module gcd_leg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  logic [gcd_pkg::TimeW-1:0]       frame_time,
  input  logic signed [gcd_pkg::ForceW-1:0] leg_force,
  input  gcd_pkg::cop_t                   cop,
  input  logic signed [gcd_pkg::ForceW-1:0] touch_threshold,
  input  logic [gcd_pkg::TimeW-1:0]       min_stance_time,
  output gcd_pkg::leg_rec_t               rec
);

  localparam logic [1:0] PH_WAIT_FLIGHT = 2'd0;
  localparam logic [1:0] PH_WAIT_TOUCH  = 2'd1;
  localparam logic [1:0] PH_STANCE      = 2'd2;
  localparam logic [1:0] PH_SWING       = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic has_cycle_r, has_cycle_nxt;
  logic [gcd_pkg::TimeW-1:0] stance_time_r, stance_time_nxt;
  logic [gcd_pkg::TimeW-1:0] swing_time_r, swing_time_nxt;
  gcd_pkg::cop_t stance_pos_r, stance_pos_nxt;

  logic touch;
  logic [gcd_pkg::TimeW-1:0] dur;
  logic real_cycle;

  assign touch = leg_force > touch_threshold;
  // stance length wraps modulo 2^32
  assign dur = swing_time_r - stance_time_r;
  assign real_cycle = dur >= min_stance_time;

  always_comb begin
    phase_nxt = phase_r;
    has_cycle_nxt = has_cycle_r;
    stance_time_nxt = stance_time_r;
    swing_time_nxt = swing_time_r;
    stance_pos_nxt = stance_pos_r;
    rec = '0;
    case (phase_r)
      PH_WAIT_FLIGHT: begin
        if (!touch) phase_nxt = PH_WAIT_TOUCH;
      end
      PH_WAIT_TOUCH: begin
        if (touch) begin
          stance_time_nxt = frame_time;
          stance_pos_nxt = cop;
          phase_nxt = PH_STANCE;
        end
      end
      PH_STANCE: begin
        if (!touch) begin
          swing_time_nxt = frame_time;
          phase_nxt = PH_SWING;
        end
      end
      PH_SWING: begin
        if (touch) begin
          rec.emit = real_cycle || has_cycle_r;
          rec.kind = real_cycle ? gcd_pkg::KIND_NEW : gcd_pkg::KIND_EXTEND;
          if (real_cycle) begin
            rec.start_time = stance_time_r;
            rec.lift_time = swing_time_r;
            rec.start_pos = stance_pos_r;
            has_cycle_nxt = 1'b1;
          end
          // the touching frame opens the next stance
          stance_time_nxt = frame_time;
          stance_pos_nxt = cop;
          phase_nxt = PH_STANCE;
        end
      end
      default: begin
        phase_nxt = PH_WAIT_FLIGHT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_FLIGHT;
      has_cycle_r <= 1'b0;
      stance_time_r <= '0;
      swing_time_r <= '0;
      stance_pos_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      has_cycle_r <= has_cycle_nxt;
      stance_time_r <= stance_time_nxt;
      swing_time_r <= swing_time_nxt;
      stance_pos_r <= stance_pos_nxt;
    end
  end

  // a cycle already emitted is never forgotten
  assert property (@(posedge clk) disable iff (!rst_n)
    has_cycle_r |=> has_cycle_r)
    else $error("leg lost its cycle flag");

  // an extend record needs an earlier cycle on this leg
  assert property (@(posedge clk) disable iff (!rst_n)
    (rec.emit && rec.kind == gcd_pkg::KIND_EXTEND) |-> has_cycle_r)
    else $error("extend record without earlier cycle");

  // a record only comes from a touch that ends a swing, and it restarts stance
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && rec.emit) |=> (phase_r == PH_STANCE))
    else $error("leg not in stance after closing a cycle");

endmodule

/* rtl/gcd_out_queue.sv */
// result record queue, up to two pushes and one pop per cycle
module gcd_out_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_cnt,
  input  gcd_pkg::out_t push_a,
  input  gcd_pkg::out_t push_b,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output gcd_pkg::out_t out_data
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

  gcd_pkg::out_t q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wr_ptr_inc;
  logic pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_inc = ptr_inc(wr_ptr_r);
  assign out_valid = count_r != '0;
  assign out_data = q_r[rd_ptr_r];
  assign pop = out_valid && out_ready;
  assign room = count_r <= ROOM_MAX;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_cnt == 2'd1) wr_ptr_nxt = wr_ptr_inc;
    else if (push_cnt == 2'd2) wr_ptr_nxt = ptr_inc(wr_ptr_inc);
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt = count_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) q_r[wr_ptr_r] <= push_a;
    if (push_cnt == 2'd2) q_r[wr_ptr_inc] <= push_b;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(push_cnt) + count_r - CW'(pop)) <= CW'(DEPTH))
    else $error("record queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("record count out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_cnt == 2'd0) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not drop the record count");

endmodule
